### rtl/core/vsc_pkg.sv
// Shared types and constants of the visual servo control step.
package vsc_pkg;

    // Fixed-point widths of the datapath
    localparam int NUM_W = 56;  // rounded dividend, meters * pixels domain
    localparam int DEN_W = 35;  // 6 * r^2
    localparam int QUO_W = 28;  // quotient bits before saturation

    localparam logic [QUO_W-1:0]   CAM_LIMIT = 28'h800_0000;   // 2^27 in Q12.16
    localparam int                 HALF_DIAG = 55706;          // per-axis early reject
    localparam logic [33:0]        SPHERE_SQ = 34'd3103113872; // 0.85^2 in Q32
    localparam logic signed [31:0] ONE_Q28   = 32'sh1000_0000;

    typedef enum logic [1:0] {
        CMD_GOTO  = 2'd0,
        CMD_FLOAT = 2'd1,
        CMD_HOLD  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_FOCAL_LENGTH    = 3'd0,
        REG_IMAGE_WIDTH     = 3'd1,
        REG_IMAGE_HEIGHT    = 3'd2,
        REG_TARGET_DIAMETER = 3'd3,
        REG_DESIRED_U       = 3'd4,
        REG_DESIRED_V       = 3'd5,
        REG_DESIRED_SIZE    = 3'd6,
        REG_TIME_STEP       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] focal_length;
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic [15:0] target_diameter;
        logic [15:0] desired_u;
        logic [15:0] desired_v;
        logic [15:0] desired_size;
        logic [15:0] time_step;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        circle_u;
        logic [15:0]        circle_v;
        logic [15:0]        circle_radius;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic signed [17:0] pos_z;
        logic signed [14:0] quat_w;
        logic signed [14:0] quat_x;
        logic signed [14:0] quat_y;
        logic signed [14:0] quat_z;
    } item_t;

    // Per-item data that rides along the arithmetic pipeline
    typedef struct packed {
        logic               no_circle;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic signed [17:0] pos_z;
        logic signed [14:0] quat_w;
        logic signed [14:0] quat_x;
        logic signed [14:0] quat_y;
        logic signed [14:0] quat_z;
    } side_t;

    typedef struct packed {
        logic                        valid;
        side_t                       side;
        logic [2:0][NUM_W-1:0]       num;
        logic [2:0]                  neg;
        logic [DEN_W-1:0]            den;
    } front_t;

    typedef struct packed {
        logic                        valid;
        side_t                       side;
        logic [2:0][QUO_W-1:0]       quo;
        logic [2:0]                  sat;
        logic [2:0]                  neg;
    } quot_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [17:0] goal_x;
        logic signed [17:0] goal_y;
        logic signed [17:0] goal_z;
    } res_t;

endpackage

### rtl/core/vsc_front.sv
// Feature error, closed-form numerators and rounded dividends (seven stages).
module vsc_front
    import vsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  item_t  item,
    input  cfg_t   cfg,
    output front_t out
);

    localparam int NST = 7;

    logic [NST-1:0]      vld_reg;
    side_t               side_reg [NST];
    side_t               side_next;

    // stage 1: centered features and errors
    logic signed [17:0]  ctr_reg [2];
    logic signed [17:0]  ctr_next [2];
    logic signed [16:0]  err_reg [2];
    logic signed [16:0]  err_next [2];
    logic signed [17:0]  esz_reg;
    logic signed [17:0]  esz_next;
    logic [15:0]         rad_reg;
    logic [31:0]         dt_reg;

    // stage 2: products
    logic signed [35:0]  ue_reg [2];
    logic signed [33:0]  re_reg [2];
    logic signed [34:0]  fe_reg;
    logic [31:0]         rr_reg;

    // stage 3: numerators and divisor
    logic signed [36:0]  n_reg [3];
    logic [DEN_W-1:0]    den_reg [5];
    logic [DEN_W-1:0]    half_reg [4];

    // stage 4..7
    logic [36:0]         mag [3];
    logic [39:0]         m5_next [3];
    logic [39:0]         m5_reg [3];
    logic [2:0]          neg_reg [4];
    logic [51:0]         pl_reg [3];
    logic [51:0]         ph_reg [3];
    logic [71:0]         a_full [3];
    logic [NUM_W-1:0]    a_reg [3];
    logic [NUM_W-1:0]    num_reg [3];

    always_comb
    begin
        side_next.no_circle = (item.circle_radius == '0);
        side_next.pos_x     = item.pos_x;
        side_next.pos_y     = item.pos_y;
        side_next.pos_z     = item.pos_z;
        side_next.quat_w    = item.quat_w;
        side_next.quat_x    = item.quat_x;
        side_next.quat_y    = item.quat_y;
        side_next.quat_z    = item.quat_z;
        ctr_next[0] = $signed({2'b00, item.circle_u}) - $signed({3'b000, cfg.image_width, 3'b000});
        ctr_next[1] = $signed({2'b00, item.circle_v}) - $signed({3'b000, cfg.image_height, 3'b000});
        err_next[0] = $signed({1'b0, cfg.desired_u}) - $signed({1'b0, item.circle_u});
        err_next[1] = $signed({1'b0, cfg.desired_v}) - $signed({1'b0, item.circle_v});
        esz_next    = $signed({2'b00, cfg.desired_size}) - $signed({1'b0, item.circle_radius, 1'b0});
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i]     = n_reg[i][36] ? 37'(-n_reg[i]) : 37'(n_reg[i]);
            m5_next[i] = {1'b0, mag[i], 2'b00} + {3'b000, mag[i]};
            a_full[i]  = {20'd0, pl_reg[i]} + {ph_reg[i], 20'd0};
        end
    end

    // Distance-time product; the user must change registers only while the pipe is empty (not enforced)
    always_ff @(posedge clk)
    begin
        dt_reg <= cfg.target_diameter * cfg.time_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < NST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            ctr_reg <= ctr_next;
            err_reg <= err_next;
            esz_reg <= esz_next;
            rad_reg <= item.circle_radius;

            for (int i = 0; i < 2; i++)
            begin
                ue_reg[i] <= ctr_reg[i] * esz_reg;
                re_reg[i] <= $signed({1'b0, rad_reg}) * err_reg[i];
                n_reg[i]  <= $signed({ue_reg[i][35], ue_reg[i]})
                           - $signed({re_reg[i][33], re_reg[i][33], re_reg[i], 1'b0});
            end
            fe_reg   <= $signed({1'b0, cfg.focal_length}) * esz_reg;
            rr_reg   <= rad_reg * rad_reg;
            n_reg[2] <= $signed({{2{fe_reg[34]}}, fe_reg});

            den_reg[0]  <= {1'b0, rr_reg, 2'b00} + {2'b00, rr_reg, 1'b0};
            half_reg[0] <= {3'b000, rr_reg} + {2'b00, rr_reg, 1'b0};
            for (int k = 1; k < 4; k++)
            begin
                den_reg[k]  <= den_reg[k-1];
                half_reg[k] <= half_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
            den_reg[4] <= den_reg[3];

            for (int i = 0; i < 3; i++)
            begin
                neg_reg[0][i] <= n_reg[i][36];
                m5_reg[i]     <= m5_next[i];
                pl_reg[i]     <= m5_reg[i][19:0] * dt_reg;
                ph_reg[i]     <= m5_reg[i][39:20] * dt_reg;
                a_reg[i]      <= a_full[i][71:16];
                num_reg[i]    <= a_reg[i] + {21'd0, half_reg[3]};
            end
        end
    end

    always_comb
    begin
        out.valid = vld_reg[NST-1];
        out.side  = side_reg[NST-1];
        for (int i = 0; i < 3; i++)
        begin
            out.num[i] = num_reg[i];
        end
        out.neg = neg_reg[3];
        out.den = den_reg[4];
    end

endmodule

### rtl/core/vsc_div.sv
// Three-lane restoring divider, one quotient bit per stage.
module vsc_div
    import vsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  front_t in,
    output quot_t  out
);

    localparam int NST = QUO_W + 1;

    logic [NST-1:0]   vld_reg;
    side_t            side_reg [NST];
    logic [DEN_W-1:0] den_reg [NST];
    logic [2:0]       neg_reg [NST];
    logic [2:0]       sat_reg [NST];
    logic [NUM_W-1:0] rem_reg [NST][3];
    logic [QUO_W-1:0] quo_reg [NST][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in.valid};
        end
    end

    // entry stage: flag quotients that cannot fit
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in.side;
            den_reg[0]  <= in.den;
            neg_reg[0]  <= in.neg;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i]    <= in.num[i];
                quo_reg[0][i]    <= '0;
                sat_reg[0][i]    <= 64'(in.num[i]) >= (64'(in.den) << QUO_W);
            end
        end
    end

    for (genvar k = 1; k < NST; k++)
    begin : g_bit
        localparam int SH = QUO_W - k;
        logic [63:0] dsh;
        logic [2:0]  hit;

        always_comb
        begin
            dsh = 64'(den_reg[k-1]) << SH;
            for (int i = 0; i < 3; i++)
            begin
                hit[i] = 64'(rem_reg[k-1][i]) >= dsh;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k][i] <= hit[i] ? rem_reg[k-1][i] - dsh[NUM_W-1:0]
                                            : rem_reg[k-1][i];
                    quo_reg[k][i] <= quo_reg[k-1][i] | (QUO_W'(hit[i]) << SH);
                end
            end
        end
    end

    always_comb
    begin
        out.valid = vld_reg[NST-1];
        out.side  = side_reg[NST-1];
        for (int i = 0; i < 3; i++)
        begin
            out.quo[i] = quo_reg[NST-1][i];
        end
        out.sat = sat_reg[NST-1];
        out.neg = neg_reg[NST-1];
    end

endmodule

### rtl/core/vsc_rot.sv
// Frame rotation, goal accumulation and workspace check (eight stages).
module vsc_rot
    import vsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  quot_t in,
    output logic  out_valid,
    output res_t  out
);

    localparam int NST = 8;

    logic [NST-1:0]     vld_reg;
    side_t              side_reg [NST];

    // stage 1
    logic [QUO_W-1:0]   cmag [3];
    logic signed [28:0] st [3];
    logic signed [28:0] ee_reg [2][3];
    logic signed [29:0] qp_reg [9];
    logic signed [29:0] qp_next [9];
    // stage 2..7
    logic signed [31:0] rm_next [9];
    logic signed [31:0] rm_reg [9];
    logic signed [60:0] pr_reg [9];
    logic signed [62:0] acc_reg [3];
    logic [62:0]        amag [3];
    logic [34:0]        rq_reg [3];
    logic [2:0]         rneg_reg;
    logic signed [36:0] pos_ext [3];
    logic signed [36:0] goal_reg [3];
    logic signed [33:0] sqw [3];
    logic [31:0]        sq_reg [3];
    logic [2:0]         far_reg;
    logic signed [17:0] g18_reg [3];
    // stage 8
    logic [33:0]        sq_sum;
    res_t               res_reg;
    res_t               res_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cmag[i] = (in.sat[i] || in.quo[i] > CAM_LIMIT) ? CAM_LIMIT : in.quo[i];
            st[i]   = in.neg[i] ? -$signed({1'b0, cmag[i]}) : $signed({1'b0, cmag[i]});
        end
        // order: xx yy zz xy xz yz wx wy wz
        qp_next[0] = in.side.quat_x * in.side.quat_x;
        qp_next[1] = in.side.quat_y * in.side.quat_y;
        qp_next[2] = in.side.quat_z * in.side.quat_z;
        qp_next[3] = in.side.quat_x * in.side.quat_y;
        qp_next[4] = in.side.quat_x * in.side.quat_z;
        qp_next[5] = in.side.quat_y * in.side.quat_z;
        qp_next[6] = in.side.quat_w * in.side.quat_x;
        qp_next[7] = in.side.quat_w * in.side.quat_y;
        qp_next[8] = in.side.quat_w * in.side.quat_z;
    end

    always_comb
    begin
        rm_next[0] = ONE_Q28 - ((32'(qp_reg[1]) + 32'(qp_reg[2])) <<< 1);
        rm_next[1] = (32'(qp_reg[3]) - 32'(qp_reg[8])) <<< 1;
        rm_next[2] = (32'(qp_reg[4]) + 32'(qp_reg[7])) <<< 1;
        rm_next[3] = (32'(qp_reg[3]) + 32'(qp_reg[8])) <<< 1;
        rm_next[4] = ONE_Q28 - ((32'(qp_reg[0]) + 32'(qp_reg[2])) <<< 1);
        rm_next[5] = (32'(qp_reg[5]) - 32'(qp_reg[6])) <<< 1;
        rm_next[6] = (32'(qp_reg[4]) - 32'(qp_reg[7])) <<< 1;
        rm_next[7] = (32'(qp_reg[5]) + 32'(qp_reg[6])) <<< 1;
        rm_next[8] = ONE_Q28 - ((32'(qp_reg[0]) + 32'(qp_reg[1])) <<< 1);
    end

    always_comb
    begin
        pos_ext[0] = 37'(side_reg[4].pos_x);
        pos_ext[1] = 37'(side_reg[4].pos_y);
        pos_ext[2] = 37'(side_reg[4].pos_z);
        for (int i = 0; i < 3; i++)
        begin
            amag[i] = acc_reg[i][62] ? 63'(-acc_reg[i]) : 63'(acc_reg[i]);
            sqw[i]  = $signed(goal_reg[i][16:0]) * $signed(goal_reg[i][16:0]);
        end
        sq_sum = 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]);

        res_next.cmd    = CMD_GOTO;
        res_next.goal_x = g18_reg[0];
        res_next.goal_y = g18_reg[1];
        res_next.goal_z = g18_reg[2];
        priority if (side_reg[6].no_circle)
        begin
            res_next = '{cmd: CMD_FLOAT, goal_x: '0, goal_y: '0, goal_z: '0};
        end
        else if (far_reg != '0 || sq_sum >= SPHERE_SQ)
        begin
            res_next = '{cmd: CMD_HOLD, goal_x: '0, goal_y: '0, goal_z: '0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in.side;
            for (int k = 1; k < NST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            // camera frame to end-effector frame: x' = -y, y' = x, z' = z
            ee_reg[0][0] <= -st[1];
            ee_reg[0][1] <= st[0];
            ee_reg[0][2] <= st[2];
            ee_reg[1]    <= ee_reg[0];
            qp_reg       <= qp_next;
            rm_reg       <= rm_next;

            for (int j = 0; j < 9; j++)
            begin
                pr_reg[j] <= rm_reg[j] * ee_reg[1][j % 3];
            end

            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i]  <= 63'(pr_reg[3*i]) + 63'(pr_reg[3*i+1]) + 63'(pr_reg[3*i+2]);
                rq_reg[i]   <= 35'((amag[i] + 63'(1 << 27)) >> 28);
                rneg_reg[i] <= acc_reg[i][62];
                goal_reg[i] <= rneg_reg[i] ? pos_ext[i] - $signed({2'b00, rq_reg[i]})
                                           : pos_ext[i] + $signed({2'b00, rq_reg[i]});
                far_reg[i]  <= (goal_reg[i] >= HALF_DIAG) || (goal_reg[i] <= -HALF_DIAG);
                sq_reg[i]   <= sqw[i][31:0];
                g18_reg[i]  <= goal_reg[i][17:0];
            end

            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out       = res_reg;

endmodule

### rtl/core/visual_servo_control_step.sv
// Top level of the visual servo control step: ports, registers, pipeline chain.
//
//  channel  | direction | beat contents (lowest bits first)
//  ---------+-----------+--------------------------------------------------------
//  s_*      | in        | circle_u, circle_v, circle_radius, pos_x/y/z, quat_w/x/y/z
//  m_*      | out       | tdata: goal_x, goal_y, goal_z; tuser: command_code
//  cfg_*    | in        | register index and value, written on cfg_wr_en
//
// One beat enters per clock while the pipe advances; each beat passes 7 front
// stages, 29 divider stages and 8 rotation stages, the last being the output register.
// The whole pipe advances together whenever the output register is empty or
// taken, so s_tready follows m_tready and a stall holds every stage in place.
// Reset clears all valid bits and loads the register defaults; data registers
// are not reset. The divider stages after the entry stage give one quotient bit each.
module visual_servo_control_step
    import vsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] circle_u, [31:16] circle_v, [47:32] circle_radius,
    // [65:48] pos_x, [83:66] pos_y, [101:84] pos_z, [116:102] quat_w,
    // [131:117] quat_x, [146:132] quat_y, [161:147] quat_z, [167:162] zero
    input  logic [167:0] s_tdata,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [17:0] goal_x, [35:18] goal_y, [53:36] goal_z, [55:54] zero
    output logic [55:0]  m_tdata,
    // [1:0] command_code
    output logic [1:0]   m_tuser,
    // configuration writes
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    cfg_t   cfg_reg;
    item_t  item;
    logic   adv;
    front_t front_q;
    quot_t  quot_q;
    logic   res_valid;
    res_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{
                focal_length:    16'd8000,
                image_width:     12'd640,
                image_height:    12'd480,
                target_diameter: 16'd6554,
                desired_u:       16'd5120,
                desired_v:       16'd3840,
                desired_size:    16'd1600,
                time_step:       16'd655
            };
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_FOCAL_LENGTH:    cfg_reg.focal_length    <= cfg_wdata;
                REG_IMAGE_WIDTH:     cfg_reg.image_width     <= cfg_wdata[11:0];
                REG_IMAGE_HEIGHT:    cfg_reg.image_height    <= cfg_wdata[11:0];
                REG_TARGET_DIAMETER: cfg_reg.target_diameter <= cfg_wdata;
                REG_DESIRED_U:       cfg_reg.desired_u       <= cfg_wdata;
                REG_DESIRED_V:       cfg_reg.desired_v       <= cfg_wdata;
                REG_DESIRED_SIZE:    cfg_reg.desired_size    <= cfg_wdata;
                REG_TIME_STEP:       cfg_reg.time_step       <= cfg_wdata;
            endcase
        end
    end

    // advance the pipe unless a finished beat is still waiting
    assign adv      = !res_valid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        item.circle_u      = s_tdata[15:0];
        item.circle_v      = s_tdata[31:16];
        item.circle_radius = s_tdata[47:32];
        item.pos_x         = s_tdata[65:48];
        item.pos_y         = s_tdata[83:66];
        item.pos_z         = s_tdata[101:84];
        item.quat_w        = s_tdata[116:102];
        item.quat_x        = s_tdata[131:117];
        item.quat_y        = s_tdata[146:132];
        item.quat_z        = s_tdata[161:147];
    end

    // features and dividends
    vsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_tvalid),
        .item     (item),
        .cfg      (cfg_reg),
        .out      (front_q)
    );

    // camera-frame step magnitudes
    vsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .in    (front_q),
        .out   (quot_q)
    );

    // rotate into base frame, add to pose, check the workspace
    vsc_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in        (quot_q),
        .out_valid (res_valid),
        .out       (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {2'b00, res.goal_z, res.goal_y, res.goal_x};
    assign m_tuser  = res.cmd;

endmodule

### rtl/core/vsc_check.sv
// Port-level checks of the visual servo control step, bound to the top level.
module vsc_check
    import vsc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // input is taken exactly when the output side can move
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output side");

    // float and hold carry a zero goal
    a_zero_goal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == CMD_FLOAT || m_tuser == CMD_HOLD) |-> m_tdata == '0)
        else $error("non-goto beat carries a goal");

    // a goto goal lies inside the workspace box
    a_goal_box: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == CMD_GOTO |->
            $signed(m_tdata[17:0]) < HALF_DIAG && $signed(m_tdata[17:0]) > -HALF_DIAG &&
            $signed(m_tdata[35:18]) < HALF_DIAG && $signed(m_tdata[35:18]) > -HALF_DIAG &&
            $signed(m_tdata[53:36]) < HALF_DIAG && $signed(m_tdata[53:36]) > -HALF_DIAG)
        else $error("goto goal outside workspace");

endmodule

bind visual_servo_control_step vsc_check u_vsc_check (.*);
